### design/mplmc_pkg.sv
package mplmc_pkg;

   localparam int MAX_PATTERNS      = 4;
   localparam int MAX_PATTERN_BYTES = 8;

   localparam int NUM_PATTERN_REGS = 4;
   localparam int BYTE_BITS        = 8;
   localparam int PATTERN_BITS     = 64;
   localparam int LENGTHS_BITS     = 16;
   localparam int LEN_BITS         = 4;
   localparam int COUNT_BITS       = 3;
   localparam int LINE_COUNT_BITS  = 16;
   localparam int TOTAL_BITS       = 32;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 64;
   localparam int REQ_DATA_BITS    = 8;
   localparam int RSP_DATA_BITS    = 88;

   localparam int WINDOW_BITS   = MAX_PATTERN_BYTES * BYTE_BITS;
   localparam int HIT_BITS      = $clog2(MAX_PATTERNS + 1);
   localparam int BYTE_IDX_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_WORD_0  = 3'd0,
      CSR_PATTERN_WORD_1  = 3'd1,
      CSR_PATTERN_WORD_2  = 3'd2,
      CSR_PATTERN_WORD_3  = 3'd3,
      CSR_PATTERN_LENGTHS = 3'd4,
      CSR_PATTERN_COUNT   = 3'd5
   } csr_index_type;

   typedef logic [MAX_PATTERN_BYTES-1:0][BYTE_BITS-1:0] window_type;

   typedef struct packed {
      logic [NUM_PATTERN_REGS-1:0][PATTERN_BITS-1:0] pattern_word;
      logic [LENGTHS_BITS-1:0]                       pattern_lengths;
      logic [COUNT_BITS-1:0]                         pattern_count;
   } cfg_type;

endpackage

### design/mplmc_csr.sv
module mplmc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mplmc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mplmc_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output mplmc_pkg::cfg_type                   cfg
);
   import mplmc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_WORD_0:  cfg_in.pattern_word[0] = csr_data;
            CSR_PATTERN_WORD_1:  cfg_in.pattern_word[1] = csr_data;
            CSR_PATTERN_WORD_2:  cfg_in.pattern_word[2] = csr_data;
            CSR_PATTERN_WORD_3:  cfg_in.pattern_word[3] = csr_data;
            CSR_PATTERN_LENGTHS: cfg_in.pattern_lengths = csr_data[LENGTHS_BITS-1:0];
            CSR_PATTERN_COUNT:   cfg_in.pattern_count = csr_data[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### design/mplmc_match.sv
module mplmc_match (
   input  mplmc_pkg::cfg_type                cfg,
   input  mplmc_pkg::window_type             window,
   input  logic [mplmc_pkg::LEN_BITS-1:0]    bytes_in_line,
   output logic [mplmc_pkg::HIT_BITS-1:0]    hits
);
   import mplmc_pkg::*;

   logic [COUNT_BITS-1:0]    active;
   logic [LEN_BITS-1:0]      len;
   logic [LEN_BITS-1:0]      back;
   logic [BYTE_BITS-1:0]     want;
   logic                     same;

   always_comb begin
      active = (cfg.pattern_count > COUNT_BITS'(MAX_PATTERNS)) ?
               COUNT_BITS'(MAX_PATTERNS) : cfg.pattern_count;
      hits = '0;
      len  = '0;
      back = '0;
      want = '0;
      same = 1'b0;
      for (int i = 0; i < NUM_PATTERN_REGS; i++) begin
         len = cfg.pattern_lengths[LEN_BITS*i +: LEN_BITS];
         if (len > LEN_BITS'(MAX_PATTERN_BYTES)) begin
            len = LEN_BITS'(MAX_PATTERN_BYTES);
         end
         same = 1'b1;
         for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
            want = cfg.pattern_word[i][BYTE_BITS*j +: BYTE_BITS];
            back = len - LEN_BITS'(1) - LEN_BITS'(j);
            if ((LEN_BITS'(j) < len) && (want != window[back[BYTE_IDX_BITS-1:0]])) begin
               same = 1'b0;
            end
         end
         if ((COUNT_BITS'(i) < active) &&
             ((len == '0) || ((bytes_in_line >= len) && same))) begin
            hits = hits + HIT_BITS'(1);
         end
      end
   end

endmodule

### design/multi_pattern_line_match_counter.sv
// Counts occurrences of up to four patterns (each up to eight bytes) in a text
// stream that carries one byte per word and marks each line end with a word
// that has tlast set. It takes one word every cycle unless stalled: a byte
// word passes an input register and parallel window compares that update the
// line count; a line-end word passes that register, then loads the result
// register. Input stalls only while a line-end word is held as the previous
// result waits on rsp_tready. The user must write pattern registers through
// the csr channel while no text is in flight; the block does not enforce it.
module multi_pattern_line_match_counter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] text_byte
   input  logic [mplmc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] line_matches, [16] line_hit, [48:17] total_matches,
   // [80:49] lines_hit, [87:81] zero
   output logic [mplmc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mplmc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mplmc_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import mplmc_pkg::*;

   cfg_type cfg;

   logic                       s1_valid_ff, s1_valid_in;
   logic [BYTE_BITS-1:0]       s1_byte_ff, s1_byte_in;
   logic                       s1_end_ff, s1_end_in;

   window_type                 window_ff, window_in;
   logic [LEN_BITS-1:0]        bil_ff, bil_in;
   logic [LINE_COUNT_BITS-1:0] tally_ff, tally_in;
   logic [TOTAL_BITS-1:0]      total_ff, total_in;
   logic [TOTAL_BITS-1:0]      hit_lines_ff, hit_lines_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [LINE_COUNT_BITS-1:0] rsp_matches_ff, rsp_matches_in;
   logic                       rsp_hit_ff, rsp_hit_in;
   logic [TOTAL_BITS-1:0]      rsp_total_ff, rsp_total_in;
   logic [TOTAL_BITS-1:0]      rsp_lines_ff, rsp_lines_in;

   window_type                 window_shift;
   logic [LEN_BITS-1:0]        bil_shift;
   logic [HIT_BITS-1:0]        hits;
   logic [LINE_COUNT_BITS:0]   tally_sum;
   logic [TOTAL_BITS:0]        total_sum;
   logic                       line_hit;
   logic                       rsp_space;
   logic                       s1_adv;
   logic                       s1_fire;
   logic                       req_fire;

   mplmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign window_shift = WINDOW_BITS'({window_ff, s1_byte_ff});
   assign bil_shift    = (bil_ff < LEN_BITS'(MAX_PATTERN_BYTES)) ? bil_ff + LEN_BITS'(1) : bil_ff;

   mplmc_match u_match (
      .cfg           (cfg),
      .window        (window_shift),
      .bytes_in_line (bil_shift),
      .hits          (hits)
   );

   assign rsp_space = !rsp_valid_ff || rsp_tready;
   assign s1_adv    = !s1_end_ff || rsp_space;
   assign s1_fire   = s1_valid_ff && s1_adv;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire  = req_tvalid && req_tready;

   assign tally_sum = {1'b0, tally_ff} + (LINE_COUNT_BITS + 1)'(hits);
   assign total_sum = {1'b0, total_ff} + (TOTAL_BITS + 1)'(tally_ff);
   assign line_hit  = (tally_ff != '0);

   always_comb begin
      s1_valid_in    = s1_valid_ff;
      s1_byte_in     = s1_byte_ff;
      s1_end_in      = s1_end_ff;
      window_in      = window_ff;
      bil_in         = bil_ff;
      tally_in       = tally_ff;
      total_in       = total_ff;
      hit_lines_in   = hit_lines_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_matches_in = rsp_matches_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_lines_in   = rsp_lines_ff;

      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_tdata[BYTE_BITS-1:0];
         s1_end_in   = req_tlast;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      if (s1_fire) begin
         if (s1_end_ff) begin
            if (line_hit) begin
               total_in = total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];
               if (hit_lines_ff != '1) begin
                  hit_lines_in = hit_lines_ff + TOTAL_BITS'(1);
               end
            end
            rsp_valid_in   = 1'b1;
            rsp_matches_in = tally_ff;
            rsp_hit_in     = line_hit;
            rsp_total_in   = total_in;
            rsp_lines_in   = hit_lines_in;
            window_in      = '0;
            bil_in         = '0;
            tally_in       = '0;
         end else begin
            window_in = window_shift;
            bil_in    = bil_shift;
            tally_in  = tally_sum[LINE_COUNT_BITS] ? '1 : tally_sum[LINE_COUNT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         window_ff    <= '0;
         bil_ff       <= '0;
         tally_ff     <= '0;
         total_ff     <= '0;
         hit_lines_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         window_ff    <= window_in;
         bil_ff       <= bil_in;
         tally_ff     <= tally_in;
         total_ff     <= total_in;
         hit_lines_ff <= hit_lines_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_byte_ff     <= s1_byte_in;
      s1_end_ff      <= s1_end_in;
      rsp_matches_ff <= rsp_matches_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_lines_ff   <= rsp_lines_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_lines_ff, rsp_total_ff, rsp_hit_ff, rsp_matches_ff});

   a_stall_only_line_end : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> (s1_end_ff && rsp_valid_ff && !rsp_tready))
      else $error("stage stalled without a pending result");

   a_line_end_clears : assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_end_ff) |=> (bil_ff == '0 && tally_ff == '0 && rsp_valid_ff))
      else $error("line state not cleared after line end");

   a_tally_grows : assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !s1_end_ff) |=> (tally_ff >= $past(tally_ff)))
      else $error("line tally decreased on a byte");

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import mplmc_pkg::*;

   localparam int CYCLE_LIMIT    = 3_000_000;
   localparam int RANDOM_ITEMS   = 450;
   localparam int PHASE_ITEMS    = 60;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct packed {
      logic [RSP_DATA_BITS-2*TOTAL_BITS-LINE_COUNT_BITS-2:0] pad;
      logic [TOTAL_BITS-1:0]      lines_hit;
      logic [TOTAL_BITS-1:0]      total_matches;
      logic                       line_hit;
      logic [LINE_COUNT_BITS-1:0] line_matches;
   } line_report_type;

   class line_match_scoreboard;
      logic [PATTERN_BITS-1:0]    pattern_word [NUM_PATTERN_REGS];
      logic [LENGTHS_BITS-1:0]    pattern_lengths;
      logic [COUNT_BITS-1:0]      pattern_count;
      logic [WINDOW_BITS-1:0]     window;
      int unsigned                line_bytes;
      logic [LINE_COUNT_BITS-1:0] line_tally;
      logic [TOTAL_BITS-1:0]      match_total;
      logic [TOTAL_BITS-1:0]      hit_lines;
      line_report_type            expected_reports [$];
      int unsigned                errors;
      int unsigned                shown;

      function new();
         foreach (pattern_word[p]) pattern_word[p] = '0;
         pattern_lengths = '0;
         pattern_count   = '0;
         window          = '0;
         line_bytes      = 0;
         line_tally      = '0;
         match_total     = '0;
         hit_lines       = '0;
         errors          = 0;
         shown           = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_PATTERN_WORD_0, CSR_PATTERN_WORD_1,
            CSR_PATTERN_WORD_2, CSR_PATTERN_WORD_3: begin
               pattern_word[idx - CSR_PATTERN_WORD_0] = value;
            end
            CSR_PATTERN_LENGTHS: pattern_lengths = value[LENGTHS_BITS-1:0];
            CSR_PATTERN_COUNT:   pattern_count = value[COUNT_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pattern_len(int p);
         int unsigned len;
         len = 32'(pattern_lengths[LEN_BITS*p +: LEN_BITS]);
         if (len > MAX_PATTERN_BYTES) len = MAX_PATTERN_BYTES;
         return len;
      endfunction

      function bit pattern_ends_here(int p);
         int unsigned len;
         len = pattern_len(p);
         if (len == 0) return 1'b1;
         if (line_bytes < len) return 1'b0;
         for (int j = 0; j < len; j++) begin
            if (pattern_word[p][BYTE_BITS*j +: BYTE_BITS] !=
                window[BYTE_BITS*(len-1-j) +: BYTE_BITS]) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_word(logic [BYTE_BITS-1:0] text_byte, logic line_end);
         int unsigned        active;
         logic [TOTAL_BITS:0] sum;
         line_report_type    report;
         if (line_end) begin
            if (line_tally != '0) begin
               sum = {1'b0, match_total} + (TOTAL_BITS + 1)'(line_tally);
               match_total = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
               if (hit_lines != '1) hit_lines = hit_lines + TOTAL_BITS'(1);
            end
            report = '0;
            report.line_matches  = line_tally;
            report.line_hit      = (line_tally != '0);
            report.total_matches = match_total;
            report.lines_hit     = hit_lines;
            expected_reports.push_back(report);
            window     = '0;
            line_bytes = 0;
            line_tally = '0;
            return;
         end
         window = {window[WINDOW_BITS-BYTE_BITS-1:0], text_byte};
         if (line_bytes < MAX_PATTERN_BYTES) line_bytes++;
         active = (pattern_count > MAX_PATTERNS) ? MAX_PATTERNS : 32'(pattern_count);
         for (int p = 0; p < active; p++) begin
            if (pattern_ends_here(p) && line_tally != '1)
               line_tally = line_tally + LINE_COUNT_BITS'(1);
         end
      endfunction

      function void report_error(string what, logic [TOTAL_BITS-1:0] want,
                                 logic [TOTAL_BITS-1:0] got);
         errors++;
         if (shown < 10) begin
            shown++;
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
         end
      endfunction

      function void check_result(logic [RSP_DATA_BITS-1:0] data);
         line_report_type got;
         line_report_type want;
         got = data;
         if (expected_reports.size() == 0) begin
            report_error("unexpected result word", '0, TOTAL_BITS'(got.line_matches));
            return;
         end
         want = expected_reports.pop_front();
         if (got.line_matches != want.line_matches)
            report_error("line_matches", TOTAL_BITS'(want.line_matches),
                         TOTAL_BITS'(got.line_matches));
         if (got.line_hit != want.line_hit)
            report_error("line_hit", TOTAL_BITS'(want.line_hit), TOTAL_BITS'(got.line_hit));
         if (got.total_matches != want.total_matches)
            report_error("total_matches", want.total_matches, got.total_matches);
         if (got.lines_hit != want.lines_hit)
            report_error("lines_hit", want.lines_hit, got.lines_hit);
      endfunction

      function int unsigned outstanding();
         return expected_reports.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_BITS-1:0]   req_tdata = '0;
   logic                       req_tlast = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]   rsp_tdata;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   csr_index_type              csr_index = CSR_PATTERN_WORD_0;
   logic [CSR_DATA_BITS-1:0]   csr_data = '0;

   line_match_scoreboard sb = new();
   int unsigned          cycle_count = 0;
   int unsigned          items_sent = 0;
   int unsigned          ready_hold = 0;
   bit                   req_gaps_on = 1'b1;
   bit                   rsp_stalls_on = 1'b1;
   logic [BYTE_BITS-1:0] alphabet [3];

   multi_pattern_line_match_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   always @(negedge clock) begin
      if (reset || !rsp_stalls_on) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold > 0) begin
         rsp_tready <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         ready_hold <= pick_gap();
      end
   end

   task automatic send_word(logic [BYTE_BITS-1:0] text_byte, logic line_end);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= text_byte;
      req_tlast  <= line_end;
      do @(posedge clock); while (!req_tready);
      sb.note_word(text_byte, line_end);
      items_sent++;
   endtask

   task automatic send_text(string text);
      for (int k = 0; k < text.len(); k++) send_word(text[k], 1'b0);
      send_word(BYTE_BITS'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(logic [PATTERN_BITS-1:0] w0, logic [PATTERN_BITS-1:0] w1,
                            logic [PATTERN_BITS-1:0] w2, logic [PATTERN_BITS-1:0] w3,
                            logic [LENGTHS_BITS-1:0] lengths, logic [COUNT_BITS-1:0] count);
      csr_write(CSR_PATTERN_WORD_0, w0);
      csr_write(CSR_PATTERN_WORD_1, w1);
      csr_write(CSR_PATTERN_WORD_2, w2);
      csr_write(CSR_PATTERN_WORD_3, w3);
      csr_write(CSR_PATTERN_LENGTHS, CSR_DATA_BITS'(lengths));
      csr_write(CSR_PATTERN_COUNT, CSR_DATA_BITS'(count));
   endtask

   // hold off until every line report is back and the pipe is empty
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic randomize_config();
      logic [PATTERN_BITS-1:0] words [NUM_PATTERN_REGS];
      logic [LENGTHS_BITS-1:0] lengths;
      logic [COUNT_BITS-1:0]   count;
      int                      r;
      foreach (alphabet[k]) alphabet[k] = BYTE_BITS'($urandom_range(0, 255));
      for (int p = 0; p < NUM_PATTERN_REGS; p++) begin
         words[p] = {$urandom, $urandom};
         if ($urandom_range(0, 9) != 0) begin
            for (int j = 0; j < MAX_PATTERN_BYTES; j++)
               words[p][BYTE_BITS*j +: BYTE_BITS] = alphabet[$urandom_range(0, 2)];
         end
         r = $urandom_range(0, 99);
         if (r < 8) lengths[LEN_BITS*p +: LEN_BITS] = LEN_BITS'($urandom_range(9, 15));
         else if (r < 15) lengths[LEN_BITS*p +: LEN_BITS] = '0;
         else if (r < 35) lengths[LEN_BITS*p +: LEN_BITS] = LEN_BITS'($urandom_range(5, 8));
         else lengths[LEN_BITS*p +: LEN_BITS] = LEN_BITS'($urandom_range(1, 4));
      end
      r = $urandom_range(0, 99);
      if (r < 8) count = '0;
      else if (r < 18) count = COUNT_BITS'($urandom_range(5, 7));
      else count = COUNT_BITS'($urandom_range(1, 4));
      configure(words[0], words[1], words[2], words[3], lengths, count);
   endtask

   task automatic send_random_line();
      logic [BYTE_BITS-1:0] line_q [$];
      int unsigned          target;
      int unsigned          len;
      int                   p;
      int                   r;
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 16);
      while (line_q.size() < target) begin
         r = $urandom_range(0, 99);
         p = $urandom_range(0, NUM_PATTERN_REGS - 1);
         len = sb.pattern_len(p);
         if (r < 30) begin
            for (int j = 0; j < len; j++)
               line_q.push_back(sb.pattern_word[p][BYTE_BITS*j +: BYTE_BITS]);
         end else if (r < 90) begin
            line_q.push_back(alphabet[$urandom_range(0, 2)]);
         end else begin
            line_q.push_back(BYTE_BITS'($urandom_range(0, 255)));
         end
      end
      foreach (line_q[k]) send_word(line_q[k], 1'b0);
      send_word(BYTE_BITS'($urandom_range(0, 255)), 1'b1);
   endtask

   initial begin
      int unsigned random_start;
      int unsigned phase_start;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // overlaps, full-width pattern, byte extremes, pattern split by a line end
      configure(64'h6161, 64'h6867_6665_6463_6261, 64'hFF, 64'hFFFF_FFFF_FFFF_FF00,
                16'h1182, 3'd4);
      send_text("aaaa");
      send_text("");
      send_text("zabcdefgh");
      send_text("abcdefg");
      send_text("h");
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);
      drain();

      // long length nibbles, empty pattern, too many patterns
      configure(64'h6161_6161_6161_6161, '1, '1, 64'h62, 16'h109F, 3'd7);
      send_text("aaaaaaaaa");
      send_text("b");
      drain();

      // no patterns in use
      configure('1, '1, '1, '1, 16'hFFFF, 3'd0);
      send_text("aaa");
      drain();

      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         randomize_config();
         req_gaps_on   = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) send_random_line();
         drain();
      end

      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
design/mplmc_pkg.sv
design/mplmc_csr.sv
design/mplmc_match.sv
design/multi_pattern_line_match_counter.sv
sim/tb_top.sv
